[src/pcs_pkg.sv]
// ----------------------------------------------------------------------------
// pcs_pkg
// shared types and constants for the piecewise contrast stretch block
// ----------------------------------------------------------------------------
package pcs_pkg;

  // fixed field widths
  localparam int PIXEL_BITS = 8;
  localparam int KNEE_BITS  = 9;
  localparam int GAIN_BITS  = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int DEF_GAIN_FRAC_BITS = 8;

  localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_KNEE    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HIGH_KNEE   = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_GAIN    = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MID_GAIN    = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HIGH_GAIN   = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MID_OFFSET  = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HIGH_OFFSET = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COLOR_MODE  = 3'd7;

  // register reset values
  localparam logic [KNEE_BITS-1:0]  RST_LOW_KNEE    = 9'd0;
  localparam logic [KNEE_BITS-1:0]  RST_HIGH_KNEE   = 9'd255;
  localparam logic [GAIN_BITS-1:0]  RST_GAIN        = 16'd256;
  localparam logic [PIXEL_BITS-1:0] RST_MID_OFFSET  = 8'd0;
  localparam logic [PIXEL_BITS-1:0] RST_HIGH_OFFSET = 8'd255;

  // mapping curve as seen by each lane
  typedef struct packed {
    logic [KNEE_BITS-1:0]  low_knee;
    logic [KNEE_BITS-1:0]  high_knee;
    logic [GAIN_BITS-1:0]  low_gain;
    logic [GAIN_BITS-1:0]  mid_gain;
    logic [GAIN_BITS-1:0]  high_gain;
    logic [PIXEL_BITS-1:0] mid_offset;
    logic [PIXEL_BITS-1:0] high_offset;
  } curve_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

[src/pcs_lane.sv]
// ----------------------------------------------------------------------------
// pcs_lane
// three-stage mapping of one channel: segment select, multiply, shift/saturate
// ----------------------------------------------------------------------------
module pcs_lane #(
  parameter int GAIN_FRAC_BITS = pcs_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                           clk,
  input  pcs_pkg::curve_t                curve,
  input  pcs_pkg::stage_en_t             en,
  input  logic                           kill,
  input  logic [pcs_pkg::PIXEL_BITS-1:0] x,
  output logic [pcs_pkg::PIXEL_BITS-1:0] res
);

  localparam int PROD_BITS = pcs_pkg::GAIN_BITS + pcs_pkg::PIXEL_BITS;
  localparam int SHR_BITS  = PROD_BITS - GAIN_FRAC_BITS;
  localparam int SUM_BITS  = SHR_BITS + 1;

  logic [pcs_pkg::KNEE_BITS-1:0]  x_ext;
  logic                           is_low;
  logic                           is_high;
  logic [pcs_pkg::PIXEL_BITS-1:0] diff_nxt;
  logic [pcs_pkg::GAIN_BITS-1:0]  gain_nxt;
  logic [pcs_pkg::PIXEL_BITS-1:0] off_nxt;

  logic [pcs_pkg::PIXEL_BITS-1:0] diff_r;
  logic [pcs_pkg::GAIN_BITS-1:0]  gain_r;
  logic [pcs_pkg::PIXEL_BITS-1:0] off1_r;

  logic [PROD_BITS-1:0]           prod_nxt;
  logic [PROD_BITS-1:0]           prod_r;
  logic [pcs_pkg::PIXEL_BITS-1:0] off2_r;

  logic [SUM_BITS-1:0]            sum;
  logic [pcs_pkg::PIXEL_BITS-1:0] res_nxt;
  logic [pcs_pkg::PIXEL_BITS-1:0] res_r;

  // stage 1: pick the segment, its slope, offset and distance from the knee
  always_comb begin
    x_ext   = {1'b0, x};
    is_low  = x_ext < curve.low_knee;
    is_high = x_ext >= curve.high_knee;
    if (kill) begin
      diff_nxt = '0;
      gain_nxt = '0;
      off_nxt  = '0;
    end else if (is_low) begin
      diff_nxt = x;
      gain_nxt = curve.low_gain;
      off_nxt  = '0;
    end else if (is_high) begin
      // knee is at most x here, so it fits the pixel width
      diff_nxt = x - curve.high_knee[pcs_pkg::PIXEL_BITS-1:0];
      gain_nxt = curve.high_gain;
      off_nxt  = curve.high_offset;
    end else begin
      diff_nxt = x - curve.low_knee[pcs_pkg::PIXEL_BITS-1:0];
      gain_nxt = curve.mid_gain;
      off_nxt  = curve.mid_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      diff_r <= diff_nxt;
      gain_r <= gain_nxt;
      off1_r <= off_nxt;
    end
  end

  // stage 2: slope times distance
  assign prod_nxt = PROD_BITS'(gain_r) * PROD_BITS'(diff_r);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r <= prod_nxt;
      off2_r <= off1_r;
    end
  end

  // stage 3: drop fraction, add offset, saturate
  assign sum     = SUM_BITS'(prod_r[PROD_BITS-1:GAIN_FRAC_BITS]) + SUM_BITS'(off2_r);
  assign res_nxt = (sum > SUM_BITS'(pcs_pkg::PIX_MAX)) ? pcs_pkg::PIX_MAX
                                                       : sum[pcs_pkg::PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en.s3) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[src/piecewise_contrast_stretch.sv]
// an accepted input beat passes the stage 1, stage 2 and stage 3 registers before it leaves as its output beat
// throughput: one pixel per cycle while the output is not stalled, through the three-stage lane pipeline
// each stage holds while the one after it is full and stalled, so bubbles close up
// reset (rst_n low, synchronous) empties the pipeline and loads the default curve:
// knees 0/255, gains 1.0, offsets 0/255, grey mode
// ----------------------------------------------------------------------------
// piecewise_contrast_stretch
// three-segment linear mapping of grey or rgb pixels; while the output is not stalled, one pixel per cycle
// ----------------------------------------------------------------------------
module piecewise_contrast_stretch #(
  parameter int GAIN_FRAC_BITS = pcs_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // chan_red, chan_green, chan_blue
  input  logic                              in_tlast,   // last_in
  // output stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // out_red, out_green, out_blue
  output logic                              out_tlast,  // last_out
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcs_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [pcs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int PB = pcs_pkg::PIXEL_BITS;

  pcs_pkg::curve_t    curve_r;
  logic               color_mode_r;
  pcs_pkg::stage_en_t en;

  logic v1_r, v2_r, v3_r;
  logic last1_r, last2_r, last3_r;
  logic rdy1, rdy2, rdy3;
  logic grey_kill;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_r.low_knee    <= pcs_pkg::RST_LOW_KNEE;
      curve_r.high_knee   <= pcs_pkg::RST_HIGH_KNEE;
      curve_r.low_gain    <= pcs_pkg::RST_GAIN;
      curve_r.mid_gain    <= pcs_pkg::RST_GAIN;
      curve_r.high_gain   <= pcs_pkg::RST_GAIN;
      curve_r.mid_offset  <= pcs_pkg::RST_MID_OFFSET;
      curve_r.high_offset <= pcs_pkg::RST_HIGH_OFFSET;
      color_mode_r        <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        pcs_pkg::REG_LOW_KNEE:    curve_r.low_knee    <= cfg_data[pcs_pkg::KNEE_BITS-1:0];
        pcs_pkg::REG_HIGH_KNEE:   curve_r.high_knee   <= cfg_data[pcs_pkg::KNEE_BITS-1:0];
        pcs_pkg::REG_LOW_GAIN:    curve_r.low_gain    <= cfg_data[pcs_pkg::GAIN_BITS-1:0];
        pcs_pkg::REG_MID_GAIN:    curve_r.mid_gain    <= cfg_data[pcs_pkg::GAIN_BITS-1:0];
        pcs_pkg::REG_HIGH_GAIN:   curve_r.high_gain   <= cfg_data[pcs_pkg::GAIN_BITS-1:0];
        pcs_pkg::REG_MID_OFFSET:  curve_r.mid_offset  <= cfg_data[PB-1:0];
        pcs_pkg::REG_HIGH_OFFSET: curve_r.high_offset <= cfg_data[PB-1:0];
        pcs_pkg::REG_COLOR_MODE:  color_mode_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-stage ready: a stage moves when it is empty or its successor moves
  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // last flag follows the pixel
  always_ff @(posedge clk) begin
    if (rdy1) last1_r <= in_tlast;
    if (rdy2) last2_r <= last1_r;
    if (rdy3) last3_r <= last2_r;
  end

  // green and blue lanes give zero in grey mode
  assign grey_kill = !color_mode_r;

  pcs_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_red (
    .clk   (clk),
    .curve (curve_r),
    .en    (en),
    .kill  (1'b0),
    .x     (in_tdata[PB-1:0]),
    .res   (out_tdata[PB-1:0])
  );

  pcs_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_green (
    .clk   (clk),
    .curve (curve_r),
    .en    (en),
    .kill  (grey_kill),
    .x     (in_tdata[2*PB-1:PB]),
    .res   (out_tdata[2*PB-1:PB])
  );

  pcs_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_blue (
    .clk   (clk),
    .curve (curve_r),
    .en    (en),
    .kill  (grey_kill),
    .x     (in_tdata[3*PB-1:2*PB]),
    .res   (out_tdata[3*PB-1:2*PB])
  );

  assign out_tvalid = v3_r;
  assign out_tlast  = last3_r;

endmodule

[src/pcs_checker.sv]
// ----------------------------------------------------------------------------
// pcs_assertions
// port-level checks for the contrast stretch pipeline
// ----------------------------------------------------------------------------
module pcs_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // a stalled output beat holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // input is never blocked while the output side is free
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with a free output");

  // with the sink ready while it passes stages 1 and 2, an accepted beat reaches the output
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("accepted beat did not reach the output");

  // reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind piecewise_contrast_stretch pcs_assertions u_pcs_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[dv/pcs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_checker
// watches the config, pixel-in and pixel-out channels of the contrast stretch,
// keeps its own copy of the curve, predicts every mapped pixel and compares
// ----------------------------------------------------------------------------
module pcs_checker #(
  parameter int GAIN_FRAC_BITS = pcs_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // chan_red, chan_green, chan_blue
  input  logic                              in_tlast,   // last_in
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [23:0]                       out_tdata,  // out_red, out_green, out_blue
  input  logic                              out_tlast,  // last_out
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pcs_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [pcs_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                fail_count,
  output int                                pending,
  output int                                checked,
  output int                                color_seen
);
  import pcs_pkg::*;

  // one pixel as it travels on either stream, red in the low bits
  typedef struct packed {
    logic                  last;
    logic [PIXEL_BITS-1:0] blue;
    logic [PIXEL_BITS-1:0] green;
    logic [PIXEL_BITS-1:0] red;
  } pixel_t;

  curve_t curve;
  logic   color_mode;
  pixel_t expected_pixels [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    color_seen = 0;
  end

  // map one level through the three segments, truncate, saturate
  function automatic logic [PIXEL_BITS-1:0] stretch_level(input logic [PIXEL_BITS-1:0] x);
    logic [KNEE_BITS-1:0] xv;
    logic [31:0]          level;
    xv = {1'b0, x};
    if (xv < curve.low_knee) begin
      level = (32'(curve.low_gain) * 32'(xv)) >> GAIN_FRAC_BITS;
    end else if (xv >= curve.high_knee) begin
      level = ((32'(curve.high_gain) * 32'(xv - curve.high_knee)) >> GAIN_FRAC_BITS)
              + 32'(curve.high_offset);
    end else begin
      level = ((32'(curve.mid_gain) * 32'(xv - curve.low_knee)) >> GAIN_FRAC_BITS)
              + 32'(curve.mid_offset);
    end
    return (level > 32'(PIX_MAX)) ? PIX_MAX : level[PIXEL_BITS-1:0];
  endfunction

  // whole pixel: grey mode zeroes green and blue
  function automatic pixel_t predict_pixel(input pixel_t px);
    pixel_t res;
    res.red   = stretch_level(px.red);
    res.green = color_mode ? stretch_level(px.green) : '0;
    res.blue  = color_mode ? stretch_level(px.blue)  : '0;
    res.last  = px.last;
    return res;
  endfunction

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // curve registers as the block should hold them
  always @(posedge clk) begin
    if (!rst_n) begin
      curve.low_knee    <= RST_LOW_KNEE;
      curve.high_knee   <= RST_HIGH_KNEE;
      curve.low_gain    <= RST_GAIN;
      curve.mid_gain    <= RST_GAIN;
      curve.high_gain   <= RST_GAIN;
      curve.mid_offset  <= RST_MID_OFFSET;
      curve.high_offset <= RST_HIGH_OFFSET;
      color_mode        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_LOW_KNEE:    curve.low_knee    <= cfg_data[KNEE_BITS-1:0];
        REG_HIGH_KNEE:   curve.high_knee   <= cfg_data[KNEE_BITS-1:0];
        REG_LOW_GAIN:    curve.low_gain    <= cfg_data[GAIN_BITS-1:0];
        REG_MID_GAIN:    curve.mid_gain    <= cfg_data[GAIN_BITS-1:0];
        REG_HIGH_GAIN:   curve.high_gain   <= cfg_data[GAIN_BITS-1:0];
        REG_MID_OFFSET:  curve.mid_offset  <= cfg_data[PIXEL_BITS-1:0];
        REG_HIGH_OFFSET: curve.high_offset <= cfg_data[PIXEL_BITS-1:0];
        REG_COLOR_MODE:  color_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // output beat first (its pixel went in at an earlier edge), then input beat
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata};
        if (expected_pixels.size() == 0) begin
          $display("%0t ns: unexpected output beat, expected none, got %h", $time, got);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          report_field("out_red",   want.red,   got.red);
          report_field("out_green", want.green, got.green);
          report_field("out_blue",  want.blue,  got.blue);
          report_field("last_out",  {7'd0, want.last}, {7'd0, got.last});
          checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(predict_pixel({in_tlast, in_tdata}));
        if (color_mode)
          color_seen++;
      end
    end
    pending = expected_pixels.size();
  end

endmodule

[dv/tb_piecewise_contrast_stretch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_contrast_stretch
// drives pixels and curve settings into the contrast stretch, with bursty
// input, a stalling output and two forced backups; pcs_checker does the scoring
// ----------------------------------------------------------------------------
module tb_piecewise_contrast_stretch;
  import pcs_pkg::*;

  localparam int FRAC_BITS = DEF_GAIN_FRAC_BITS;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [23:0]              in_tdata;   // chan_red, chan_green, chan_blue
  logic                     in_tlast;   // last_in
  logic                     out_tvalid;
  logic                     out_tready;
  logic [23:0]              out_tdata;  // out_red, out_green, out_blue
  logic                     out_tlast;  // last_out
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int color_seen;

  // knees currently loaded, used to aim levels at the segment edges
  logic [KNEE_BITS-1:0] knee_lo = RST_LOW_KNEE;
  logic [KNEE_BITS-1:0] knee_hi = RST_HIGH_KNEE;
  int curves_run = 1;
  int stalls_asked = 0;
  int stalls_done = 0;

  always #10 clk = ~clk;

  piecewise_contrast_stretch #(.GAIN_FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  pcs_checker #(.GAIN_FRAC_BITS(FRAC_BITS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked), .color_seen(color_seen)
  );

  // one pixel beat, held until accepted
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic last);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // level near a knee, at a rail, or anywhere
  function automatic logic [7:0] pick_level();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 255);
      1: v = int'(knee_lo) + int'($urandom_range(0, 4)) - 2;
      2: v = int'(knee_hi) + int'($urandom_range(0, 4)) - 2;
      default: v = $urandom_range(0, 1) ? 255 : 0;
    endcase
    if (v < 0)
      v = 0;
    if (v > 255)
      v = 255;
    return v[7:0];
  endfunction

  // random pixels in bursts, with idle gaps between bursts bounded by gap_max
  task automatic run_pixels(input int n, input int gap_max);
    int burst;
    int gap;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      send_pixel(pick_level(), pick_level(), pick_level(), $urandom_range(0, 15) == 0);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  endtask

  // rails, single-bit steps and alternating patterns on every channel
  task automatic send_probes();
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd1,   8'd254, 8'd128, 1'b0);
    send_pixel(8'd254, 8'd1,   8'd127, 1'b0);
    send_pixel(8'h55,  8'hAA,  8'h0F,  1'b0);
    send_pixel(8'hAA,  8'h55,  8'hF0,  1'b1);
    send_pixel(8'd63,  8'd64,  8'd65,  1'b0);
    send_pixel(8'd191, 8'd192, 8'd193, 1'b0);
    send_pixel(8'd128, 8'd0,   8'd255, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50,  1'b1);
  endtask

  // drop valid and let every pixel in flight come out
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // load a full curve while the pipeline is empty
  task automatic set_curve(input logic [8:0] lk, input logic [8:0] hk,
                           input logic [15:0] lg, input logic [15:0] mg, input logic [15:0] hg,
                           input logic [7:0] mo, input logic [7:0] ho, input logic cm);
    wait_drained();
    write_reg(REG_LOW_KNEE,    16'(lk));
    write_reg(REG_HIGH_KNEE,   16'(hk));
    write_reg(REG_LOW_GAIN,    lg);
    write_reg(REG_MID_GAIN,    mg);
    write_reg(REG_HIGH_GAIN,   hg);
    write_reg(REG_MID_OFFSET,  16'(mo));
    write_reg(REG_HIGH_OFFSET, 16'(ho));
    write_reg(REG_COLOR_MODE,  16'(cm));
    @(negedge clk);
    cfg_valid <= 1'b0;
    knee_lo = lk;
    knee_hi = hk;
    curves_run++;
  endtask

  function automatic logic [15:0] pick_gain();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 1023));
  endfunction

  // output side: ready patterns, plus a long hold whenever one is asked for
  initial begin : sink_ctrl
    int mode;
    int run_len;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (stalls_asked > stalls_done) begin
        repeat (100) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
        stalls_done++;
      end else begin
        mode = $urandom_range(0, 2);
        run_len = $urandom_range(1, 40);
        repeat (run_len) begin
          @(negedge clk);
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= $urandom_range(0, 1);
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr  = REG_LOW_KNEE;
    cfg_data  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset curve, grey mode
    send_probes();

    // ordinary s-curve in color
    set_curve(9'd64, 9'd192, 16'h0080, 16'h0200, 16'h0100, 8'd32, 8'd200, 1'b1);
    send_probes();
    run_pixels(150, 4);

    // both knees past the top: everything on the low segment, full-scale gain saturates
    set_curve(9'd256, 9'd256, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 1'b1);
    stalls_asked++;
    run_pixels(100, 0);

    // crossed knees
    set_curve(9'd200, 9'd50, 16'h0180, 16'hFFFF, 16'h0040, 8'd10, 8'd20, 1'b1);
    run_pixels(150, 3);

    // everything zero: whole range on a flat high segment
    set_curve(9'd0, 9'd0, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0, 1'b0);
    run_pixels(100, 2);

    // high segment unreachable
    set_curve(9'd0, 9'd256, 16'h0100, 16'h0100, 16'hFFFF, 8'd0, 8'd0, 1'b1);
    run_pixels(100, 0);

    // random curves
    for (int p = 0; p < 8; p++) begin
      set_curve(9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)),
                pick_gain(), pick_gain(), pick_gain(),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
      if (p == 4)
        stalls_asked++;
      run_pixels(120, (p % 3 == 0) ? 0 : 6);
    end

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Mapped %0d pixels (%0d in color mode) across %0d curves", checked, color_seen,
             curves_run);
    $display("Curves included knees at 0 and 256, crossed knees, full-scale gains; %0d long stalls",
             stalls_done);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
